[sv/sws_pkg.sv]
// Shared types, constants and width helpers for the search stack.
`timescale 1ns / 1ps

package sws_pkg;

  // Storage geometry
  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Port field widths
  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 9;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SRCH
  } state_t;

  localparam int TO_W  = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int POSCP = (CNT_W < POS_W) ? CNT_W : POS_W;

  // Operand field -> stored word (low bits kept, zero fill above)
  function automatic logic [DATA_WIDTH-1:0] to_word(input logic [VALUE_W-1:0] v);
    logic [DATA_WIDTH-1:0] r;
    r = '0;
    for (int i = 0; i < TO_W; i++) r[i] = v[i];
    return r;
  endfunction

  // Stored word -> result field (zero fill above)
  function automatic logic [VALUE_W-1:0] from_word(input logic [DATA_WIDTH-1:0] w);
    logic [VALUE_W-1:0] r;
    r = '0;
    for (int i = 0; i < TO_W; i++) r[i] = w[i];
    return r;
  endfunction

  // Position counter -> result field, masked to the field width
  function automatic logic [POS_W-1:0] pos_field(input logic [CNT_W-1:0] p);
    logic [POS_W-1:0] r;
    r = '0;
    for (int i = 0; i < POSCP; i++) r[i] = p[i];
    return r;
  endfunction

endpackage

[sv/sws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/stack_with_search.sv]
// Top level: bounded LIFO store of signed words with push, pop and search.
//
// Usage:
//   Input channel: drive in_opcode / in_operand_value and raise start; the
//   item is taken at a rising edge where start is high and busy is low.
//   Opcodes: push, pop, search; the unused code gives an all-zero result.
//   Result channel: out_valid is high for exactly one cycle per item, with
//   out_popped_value, out_found_position and out_status alongside it.
//   The receiver cannot stall; every result must be taken when shown.
// Flow:
//   push, full push, empty pop, empty search, unused code: the result shows in
//   the cycle after accept, busy stays low, so a new item can follow every cycle.
//   pop: one entry memory read (registered), then the result register; busy is high.
//   search reading k entries (the hit is the k-th from the top, or k is the
//   entry count when nothing matches, so k is at most DEPTH): busy stays high
//   while the entry memory's single read port reads one entry a cycle, then the result is registered.
// Reset: rst_n (synchronous, active low) empties the stack by clearing the
//   entry count; the entry memory itself is not cleared and needs no sweep.
`timescale 1ns / 1ps

module stack_with_search (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [sws_pkg::OPCODE_W-1:0]         in_opcode,
  input  logic signed [sws_pkg::VALUE_W-1:0]   in_operand_value,
  output logic                                 out_valid,
  output logic signed [sws_pkg::VALUE_W-1:0]   out_popped_value,
  output logic [sws_pkg::POS_W-1:0]            out_found_position,
  output logic [sws_pkg::STATUS_W-1:0]         out_status
);

  import sws_pkg::*;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_popped_r, out_popped_nxt;
  logic [POS_W-1:0]      out_pos_r, out_pos_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  accept;
  logic                  is_full;
  logic                  is_empty;
  logic [ADDR_W-1:0]     top_addr;
  logic                  hit;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign top_addr = ADDR_W'(count_r - 1'b1);
  assign hit      = (ram_rdata == key_r);

  // Entry memory. Writes happen only in idle on a push, and a read of the
  // written entry can only be issued in a later cycle, so no forwarding is needed.
  sws_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_POP && !is_empty) begin
            state_nxt = S_POP;
          end else if (in_opcode == OP_SEARCH && !is_empty) begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_POP: begin
        state_nxt = S_IDLE;
      end
      S_SRCH: begin
        if (hit || idx_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, memory control and result
  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_popped_nxt = '0;
    out_pos_nxt    = '0;
    out_status_nxt = ST_OK;
    ram_we         = 1'b0;
    ram_waddr      = ADDR_W'(count_r);
    ram_wdata      = to_word(in_operand_value);
    ram_raddr      = top_addr;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority case (in_opcode)
            OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            OP_SEARCH: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NOT_FOUND;
              end else begin
                idx_nxt = top_addr;
                pos_nxt = CNT_W'(1);
                key_nxt = to_word(in_operand_value);
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        out_valid_nxt  = 1'b1;
        out_popped_nxt = from_word(ram_rdata);
      end
      S_SRCH: begin
        // ram_rdata holds the entry at idx_r, position pos_r counting from 1 at the top
        if (hit) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_field(pos_r);
        end else if (idx_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOT_FOUND;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          pos_nxt   = pos_r + 1'b1;
          ram_raddr = idx_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    out_popped_r <= out_popped_nxt;
    out_pos_r    <= out_pos_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_popped_value   = $signed(out_popped_r);
  assign out_found_position = out_pos_r;
  assign out_status         = out_status_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_srch_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH |-> (CNT_W'(idx_r) + pos_r) == count_r)
    else $error("search index and position out of step");

  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |=> out_valid && state_r == S_IDLE)
    else $error("pop did not finish in one read");

  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_opcode == OP_PUSH && !is_full |=>
      out_valid && out_status == ST_OK && count_r == $past(count_r) + 1'b1)
    else $error("push did not complete");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE && !is_full)
    else $error("memory write outside idle push");

endmodule

[bench/tb_stack_with_search.sv]
// Self-checking testbench for the search stack: result checker package and top module.
`timescale 1ns / 1ps

package stack_check_pkg;
  import sws_pkg::*;

  // The one opcode with no operation behind it
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned MAX_PRINTED = 50;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped;
    logic [POS_W-1:0]          position;
    logic [STATUS_W-1:0]       status;
  } stack_reply_t;

  // Shadow stack plus the queue of replies still owed by the block
  class stack_checker;
    logic [DATA_WIDTH-1:0] words [DEPTH];
    int unsigned           level;
    stack_reply_t          awaited[$];
    int unsigned           mismatches;

    function new();
      level      = 0;
      mismatches = 0;
    endfunction

    // Apply one command to the shadow stack and return the reply it owes
    function stack_reply_t apply_command(input logic [OPCODE_W-1:0] op,
                                         input logic [VALUE_W-1:0] val);
      stack_reply_t          r;
      logic [DATA_WIDTH-1:0] word;
      r    = '0;
      word = val;
      case (op)
        OP_PUSH: begin
          if (level >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            words[level] = word;
            level++;
          end
        end
        OP_POP: begin
          if (level == 0) begin
            r.status = ST_EMPTY;
          end else begin
            level--;
            r.popped = words[level];
          end
        end
        OP_SEARCH: begin
          // first equal entry counting down from the top
          r.status = ST_NOT_FOUND;
          for (int unsigned d = 1; d <= level; d++) begin
            if (words[level - d] == word) begin
              r.position = d[POS_W-1:0];
              r.status   = ST_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_command(input logic [OPCODE_W-1:0] op,
                               input logic [VALUE_W-1:0] val);
      awaited.push_back(apply_command(op, val));
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare one reply from the block with the oldest owed reply
    task check_reply(input logic signed [VALUE_W-1:0] popped,
                     input logic [POS_W-1:0] position,
                     input logic [STATUS_W-1:0] status);
      stack_reply_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("reply with nothing owed, status %0d", status));
        return;
      end
      want = awaited.pop_front();
      if (popped !== want.popped)
        report_mismatch($sformatf("popped_value %0d, want %0d", popped, want.popped));
      if (position !== want.position)
        report_mismatch($sformatf("found_position %0d, want %0d", position,
                                  want.position));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
    endtask
  endclass

endpackage

module tb_stack_with_search;
  import sws_pkg::*;
  import stack_check_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 7;
  localparam int QUIET_LIMIT  = 4 * (DEPTH + 16);
  localparam int TAIL_CYCLES  = DEPTH + 8;
  localparam int POOL_SIZE    = 12;
  localparam logic [VALUE_W-1:0] BOTTOM_MARKER = 32'h5A5A_C3C3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OPCODE_W-1:0]        in_opcode        = '0;
  logic signed [VALUE_W-1:0]  in_operand_value = '0;
  logic                       out_valid;
  logic signed [VALUE_W-1:0]  out_popped_value;
  logic [POS_W-1:0]           out_found_position;
  logic [STATUS_W-1:0]        out_status;

  stack_checker         sb;
  logic [VALUE_W-1:0]   value_pool [POOL_SIZE];
  int unsigned          gap_percent = 0;
  int unsigned          quiet_cycles = 0;

  stack_with_search uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_operand_value   (in_operand_value),
    .out_valid          (out_valid),
    .out_popped_value   (out_popped_value),
    .out_found_position (out_found_position),
    .out_status         (out_status)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Accepted commands feed the shadow stack
  always @(posedge clk) begin
    if (rst_n && start && busy === 1'b0)
      sb.note_command(in_opcode, in_operand_value);
  end

  // Every strobed reply is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if ($isunknown(out_valid))
        sb.report_mismatch("out_valid unknown");
      else if (out_valid)
        sb.check_reply(out_popped_value, out_found_position, out_status);
    end
  end

  // Present one command and hold it until the block takes it
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val);
    @(negedge clk);
    start            <= 1'b1;
    in_opcode        <= op;
    in_operand_value <= val;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Idle cycles carry junk on the data ports
  task automatic idle_for(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start            <= 1'b0;
      in_opcode        <= OPCODE_W'($urandom);
      in_operand_value <= $urandom;
    end
  endtask

  // Hold off until every owed reply has come back
  task automatic settle();
    do idle_for(1); while (sb.awaited.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 60)
      return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Mixed traffic; values lean on a small pool so searches hit
  task automatic random_traffic(input int unsigned count, input int unsigned push_pct,
                                input int unsigned pop_pct, input int unsigned search_pct);
    logic [OPCODE_W-1:0] op;
    int unsigned         roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < push_pct)
        op = OP_PUSH;
      else if (roll < push_pct + pop_pct)
        op = OP_POP;
      else if (roll < push_pct + pop_pct + search_pct)
        op = OP_SEARCH;
      else
        op = OP_UNUSED;
      if ($urandom_range(99) < gap_percent)
        idle_for($urandom_range(1, 4));
      send_item(op, pick_value());
    end
  endtask

  // Empty the stack, fill it to the brim, probe it full, then drain it
  task automatic fill_and_drain();
    logic [VALUE_W-1:0] v;
    int unsigned        held;
    settle();
    held = sb.level;
    repeat (held) send_item(OP_POP, $urandom);
    send_item(OP_PUSH, BOTTOM_MARKER);
    repeat (DEPTH - 1) begin
      do v = $urandom; while (v == BOTTOM_MARKER);
      send_item(OP_PUSH, v);
    end
    repeat (3) send_item(OP_PUSH, $urandom);
    // deepest hit, then a search that most likely misses and walks every entry
    send_item(OP_SEARCH, BOTTOM_MARKER);
    send_item(OP_SEARCH, pick_value());
    send_item(OP_UNUSED, $urandom);
    repeat (DEPTH + 1) send_item(OP_POP, $urandom);
  endtask

  // Watchdog on cycles with no traffic in either direction
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || out_valid === 1'b1)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb = new();
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'hFFFF_FFFF;
    value_pool[3] = 32'h0000_0000;
    value_pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty cases, unused opcode, extreme values, duplicates
    send_item(OP_POP, 32'h0);
    send_item(OP_SEARCH, 32'h0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_PUSH, 32'h7FFF_FFFF);
    send_item(OP_PUSH, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 32'h0000_0000);
    send_item(OP_SEARCH, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 32'h8000_0000);
    send_item(OP_SEARCH, 32'd12345);
    send_item(OP_PUSH, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 32'h0);
    repeat (5) send_item(OP_POP, 32'hFFFF_FFFF);
    send_item(OP_POP, 32'h0);
    send_item(OP_SEARCH, 32'hFFFF_FFFF);

    // Random traffic, gapped
    gap_percent = 27;
    random_traffic(500, 45, 30, 20);

    // Long stretch with no gaps
    gap_percent = 0;
    fill_and_drain();

    // Push-heavy traffic that runs into the full case again
    gap_percent = 27;
    random_traffic(700, 60, 20, 15);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
sv/sws_pkg.sv
sv/sws_ram.sv
sv/stack_with_search.sv
bench/tb_stack_with_search.sv
